// ===== sv/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared constants and types for the sliding window median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

   localparam int DEPTH  = 64;
   localparam int DATA_W = 32;
   localparam int AGE_W  = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int SIZE_W = $clog2(DEPTH) + 1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);
   localparam logic [DATA_W-1:0] SIGN_BIAS  = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic [DATA_W-1:0] word_type;
   typedef logic [AGE_W-1:0]  age_type;

   // what a cell shows its right neighbor (removal prefix) and left neighbor
   typedef struct packed {
      logic     valid;
      logic     lt;
      logic     rm_seen;
      word_type val;
      age_type  age;
   } cell_a_type;

   // the cell's entry once the outgoing sample is taken out of the row
   typedef struct packed {
      logic     s_valid;
      logic     s_lt;
      word_type s_val;
      age_type  s_age;
   } cell_b_type;

   typedef struct packed {
      logic     shift;
      logic     clear;
      logic     full;
      word_type sample;
      age_type  last_age;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== sv/sliding_window_median_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_median_top
// Running median filter over the last window_size signed samples.
// ----------------------------------------------------------------------------
// One sample is taken per clock while the output register is not stalled. Samples
// sit in a row of 64 sorted cells; each beat removes the oldest sample and inserts
// the new one, all cells working at once. Once the window is full, each sample gives
// the lower median, which is picked from the updated row and held in an output
// register, so a result is offered only once both the row and that register have
// been written.
// The first window_size-1 samples after reset or a window_size write give no
// result. window_size 0 acts as 1 and values above 64 act as 64.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_median_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] sample
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] median
   input  wire logic        csr_wr_en,
   input  wire logic [6:0]  csr_wr_data  // [6:0] window_size
);

   localparam int SW = swm_pkg::SIZE_W;

   logic [SW-1:0]         size_ff, size_in;
   logic [SW-1:0]         fill_ff, fill_in;
   logic                  pend_ff, pend_in;
   logic                  out_valid_ff, out_valid_in;
   swm_pkg::word_type     out_data_ff, out_data_in;

   logic [SW-1:0]         k_eff;
   logic [SW-1:0]         mid_wide;
   logic [swm_pkg::IDX_W-1:0] mid;
   logic                  full;
   logic                  adv;
   logic                  req_fire;
   swm_pkg::cell_ctl_type ctl;
   logic [swm_pkg::DEPTH-1:0] valid_vec;
   swm_pkg::word_type     values [swm_pkg::DEPTH];

   always_comb begin
      if (size_ff == '0) begin
         k_eff = SW'(1);
      end else if (size_ff > SW'(swm_pkg::DEPTH)) begin
         k_eff = SW'(swm_pkg::DEPTH);
      end else begin
         k_eff = size_ff;
      end
   end

   // lower median sits at ceil(k/2)-1
   assign mid_wide = (k_eff + SW'(1)) >> 1;
   assign mid      = swm_pkg::IDX_W'(mid_wide - SW'(1));
   assign full     = (fill_ff == k_eff);

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = !pend_ff || adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      ctl.shift    = req_fire;
      ctl.clear    = csr_wr_en;
      ctl.full     = full;
      ctl.sample   = req_tdata ^ swm_pkg::SIGN_BIAS;
      ctl.last_age = swm_pkg::AGE_W'(k_eff - SW'(1));
   end

   swm_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .valid_vec (valid_vec),
      .values    (values)
   );

   always_comb begin
      size_in      = size_ff;
      fill_in      = fill_ff;
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (adv) begin
         out_valid_in = pend_ff;
         pend_in      = 1'b0;
         if (pend_ff) begin
            out_data_in = values[mid] ^ swm_pkg::SIGN_BIAS;
         end
      end

      if (csr_wr_en) begin
         size_in = csr_wr_data;
         fill_in = '0;
      end else if (req_fire) begin
         if (!full) begin
            fill_in = fill_ff + SW'(1);
         end
         pend_in = full || (fill_ff + SW'(1) == k_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= swm_pkg::SIZE_RESET;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // occupied cells always match the fill count
   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(fill_ff))
      else $error("cell occupancy differs from fill count");

   // occupied cells form one run from the low end
   a_fill_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + swm_pkg::DEPTH'(1)) & valid_vec) == '0)
      else $error("occupied cells not packed");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= k_eff)
      else $error("fill count above window size");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(pend_ff))
      else $error("result beat without pending median");

endmodule

`default_nettype wire

// ===== sv/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: value, age and valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire swm_pkg::cell_ctl_type ctl,
   input  wire swm_pkg::cell_a_type  left_a,
   input  wire swm_pkg::cell_a_type  right_a,
   input  wire swm_pkg::cell_b_type  left_b,
   output swm_pkg::cell_a_type       own_a,
   output swm_pkg::cell_b_type       own_b,
   output logic                      valid,
   output swm_pkg::word_type         value
);

   logic              valid_ff, valid_in;
   swm_pkg::word_type val_ff, val_in;
   swm_pkg::age_type  age_ff, age_in;
   logic              lt;
   logic              rm;

   assign lt = valid_ff && (val_ff < ctl.sample);
   assign rm = ctl.full && valid_ff && (age_ff == ctl.last_age);

   always_comb begin
      own_a.valid   = valid_ff;
      own_a.lt      = lt;
      own_a.rm_seen = left_a.rm_seen | rm;
      own_a.val     = val_ff;
      own_a.age     = age_ff;
   end

   // entry after removal: take the right neighbor once the removed one is at or left of us
   always_comb begin
      if (own_a.rm_seen) begin
         own_b.s_valid = right_a.valid;
         own_b.s_lt    = right_a.lt;
         own_b.s_val   = right_a.val;
         own_b.s_age   = right_a.age;
      end else begin
         own_b.s_valid = valid_ff;
         own_b.s_lt    = lt;
         own_b.s_val   = val_ff;
         own_b.s_age   = age_ff;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      val_in   = val_ff;
      age_in   = age_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         valid_in = left_b.s_valid;
         if (own_b.s_lt) begin
            val_in = own_b.s_val;
            age_in = own_b.s_age + swm_pkg::AGE_W'(1);
         end else if (left_b.s_lt) begin
            // insertion point
            val_in = ctl.sample;
            age_in = '0;
         end else begin
            val_in = left_b.s_val;
            age_in = left_b.s_age + swm_pkg::AGE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      val_ff <= val_in;
      age_ff <= age_in;
   end

   assign valid = valid_ff;
   assign value = val_ff;

endmodule

`default_nettype wire

// ===== sv/swm_chain.sv =====
// ----------------------------------------------------------------------------
// swm_chain
// Row of sorted cells holding the window in ascending biased order.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_chain (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire swm_pkg::cell_ctl_type ctl,
   output logic [swm_pkg::DEPTH-1:0]  valid_vec,
   output swm_pkg::word_type          values [swm_pkg::DEPTH]
);

   localparam swm_pkg::cell_a_type TIE_A = '0;
   // left of the first cell acts as a valid entry below every sample
   localparam swm_pkg::cell_b_type TIE_B = '{s_valid: 1'b1, s_lt: 1'b1,
                                             s_val: '0, s_age: '0};

   swm_pkg::cell_a_type a_bus [swm_pkg::DEPTH];
   swm_pkg::cell_b_type b_bus [swm_pkg::DEPTH];

   for (genvar i = 0; i < swm_pkg::DEPTH; i++) begin : g_cell
      swm_pkg::cell_a_type left_a, right_a;
      swm_pkg::cell_b_type left_b;

      if (i == 0) begin : g_first
         assign left_a = TIE_A;
         assign left_b = TIE_B;
      end else begin : g_mid
         assign left_a = a_bus[i-1];
         assign left_b = b_bus[i-1];
      end

      if (i == swm_pkg::DEPTH - 1) begin : g_last
         assign right_a = TIE_A;
      end else begin : g_next
         assign right_a = a_bus[i+1];
      end

      swm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .left_a  (left_a),
         .right_a (right_a),
         .left_b  (left_b),
         .own_a   (a_bus[i]),
         .own_b   (b_bus[i]),
         .valid   (valid_vec[i]),
         .value   (values[i])
      );
   end

endmodule

`default_nettype wire

// ===== tb/tb_sliding_window_median_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_median_top
// Self-checking bench for the running median filter.
// ----------------------------------------------------------------------------
// Samples are streamed through the filter under random gaps and back-pressure.
// A behavioral copy of the window (ring plus sorted list) predicts each median,
// which is checked against every output beat in order. The window size is
// rewritten between phases, covering zero, one, even sizes, full depth,
// oversize values and a restart before the window has filled.
// ----------------------------------------------------------------------------

module tb_sliding_window_median_top;

   localparam int LIMIT    = 200000;
   localparam int SETTLE   = 8;
   localparam int N_PHASES = 17;
   localparam int N_CORNER = 20;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_tvalid  = 1'b0;
   logic             req_tready;
   logic [31:0]      req_tdata   = '0;
   logic             rsp_tvalid;
   logic             rsp_tready  = 1'b0;
   logic [31:0]      rsp_tdata;
   logic             csr_wr_en   = 1'b0;
   logic [6:0]       csr_wr_data = '0;

   // window model
   swm_pkg::word_type win_hist   [swm_pkg::DEPTH];
   swm_pkg::word_type win_sorted [swm_pkg::DEPTH];
   int                win_fill   = 0;
   int                win_oldest = 0;
   logic [6:0]        win_size   = 7'd3;

   swm_pkg::word_type pending_samples [$];
   swm_pkg::word_type median_expected [$];

   logic req_taken    = 1'b0;
   int   samples_sent = 0;
   int   results_seen = 0;
   int   error_count  = 0;
   int   cycle_count  = 0;
   int   hold_left    = 0;
   logic hold_done    = 1'b0;

   int         phase_sizes [N_PHASES] = '{1, 0, 2, 64, 5, 127, 4, 65, 7, 64, 32, 6, 100,
                                          2, 16, 3, 9};
   int         phase_lens  [N_PHASES] = '{80, 80, 70, 20, 80, 150, 80, 150, 80, 150, 120,
                                          80, 150, 70, 100, 80, 80};
   swm_pkg::word_type corner_samples [N_CORNER] = '{
      32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff, 32'h00000001,
      32'h00000005, 32'h00000005, 32'h00000005, 32'hfffffff9, 32'hfffffff9,
      32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h00000000,
      32'h80000001, 32'h7ffffffe, 32'h00000003, 32'h00000002, 32'h00000001};

   sliding_window_median_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // slide the window by one sample and queue the median once it is full
   task automatic median_predict(input swm_pkg::word_type s);
      int k;
      int slot;
      int pos;
      int hit;
      k = (win_size == 0) ? 1 : (win_size > swm_pkg::DEPTH) ? swm_pkg::DEPTH : win_size;
      if (win_fill > k || win_oldest >= k) begin
         win_fill   = 0;
         win_oldest = 0;
      end
      if (win_fill == k) begin
         slot = win_oldest;
         hit  = -1;
         for (int i = 0; i < win_fill; i++)
            if (hit < 0 && win_sorted[i] == win_hist[slot]) hit = i;
         if (hit >= 0)
            for (int i = hit; i < win_fill - 1; i++) win_sorted[i] = win_sorted[i + 1];
         win_fill--;
         win_oldest = (win_oldest + 1) % k;
      end else begin
         slot = (win_oldest + win_fill) % k;
      end
      win_hist[slot] = s;
      pos = 0;
      while (pos < win_fill && $signed(win_sorted[pos]) < $signed(s)) pos++;
      for (int i = win_fill; i > pos; i--) win_sorted[i] = win_sorted[i - 1];
      win_sorted[pos] = s;
      win_fill++;
      if (win_fill == k)
         median_expected.insert(median_expected.size(), win_sorted[(k + 1) / 2 - 1]);
   endtask

   function automatic swm_pkg::word_type pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'h80000000;
               1:       return 32'h7fffffff;
               2:       return 32'h00000000;
               default: return 32'hffffffff;
            endcase
         end
         // narrow range so duplicates land in the window
         1, 2, 3: return 32'($signed($urandom_range(0, 15)) - 8);
         default: return $urandom;
      endcase
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_tvalid || median_expected.size() != 0)
         @(negedge clock);
      // samples that give no median may still be in flight
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_window(input logic [6:0] size_val);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size_val;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_samples.size() != 0 &&
             ((samples_sent >= 700 && samples_sent < 1000) || $urandom_range(0, 99) >= 7)) begin
            req_tdata  <= pending_samples.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off to back the filter up
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && results_seen >= 200) begin
         rsp_tready <= 1'b0;
         hold_left  <= 300;
         hold_done  <= 1'b1;
      end else if (results_seen >= 500 && results_seen < 800) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 7);
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      swm_pkg::word_type want;
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end else if (reset) begin
         req_taken  = 1'b0;
         win_fill   = 0;
         win_oldest = 0;
         win_size   = 7'd3;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (csr_wr_en) begin
            win_size   = csr_wr_data;
            win_fill   = 0;
            win_oldest = 0;
         end
         if (req_taken) begin
            median_predict(req_tdata);
            samples_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (median_expected.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected median beat %0d at cycle %0d",
                           $signed(rsp_tdata), cycle_count);
            end else begin
               want = median_expected.pop_front();
               if (rsp_tdata !== want) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("median mismatch at cycle %0d: expected %0d, got %0d",
                              cycle_count, $signed(want), $signed(rsp_tdata));
               end
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window size of three
      for (int i = 0; i < N_CORNER; i++)
         pending_samples.insert(pending_samples.size(), corner_samples[i]);
      for (int i = 0; i < 40; i++)
         pending_samples.insert(pending_samples.size(), pick_sample());

      for (int p = 0; p < N_PHASES; p++) begin
         write_window(7'(phase_sizes[p]));
         for (int i = 0; i < phase_lens[p]; i++)
            pending_samples.insert(pending_samples.size(), pick_sample());
      end

      wait_drained();
      repeat (2 * SETTLE) @(negedge clock);
      if (error_count == 0 && median_expected.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
